// File: rtl/esp_pkg.sv
package esp_pkg;

  localparam int unsigned POOL_DEPTH_DEF      = 16;
  localparam int unsigned SOLUTION_LENGTH_DEF = 64;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_MAXIMIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SORTED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd3;

  localparam logic [1:0] OC_DUPLICATE = 2'd0;
  localparam logic [1:0] OC_NOT_BETTER = 2'd1;
  localparam logic [1:0] OC_APPENDED  = 2'd2;
  localparam logic [1:0] OC_REPLACED  = 2'd3;

  typedef struct packed {
    logic signed [31:0] element_value;
    logic signed [31:0] objective_value;
    logic               last_element;
  } in_word_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] outcome;
    logic [3:0] position;
    logic [4:0] pool_count;
  } out_word_t;

  typedef struct packed {
    logic        maximize_mode;
    logic [4:0]  pool_limit;
    logic        keep_sorted;
    logic [30:0] match_tol;
  } cfg_t;

endpackage

// File: rtl/esp_fifo.sv
module esp_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  esp_pkg::in_word_t push_word,
  output logic              full,
  input  logic              pop,
  output esp_pkg::in_word_t pop_word,
  output logic              empty
);

  localparam int unsigned DEPTH = 4;

  esp_pkg::in_word_t buf_r [DEPTH];
  logic [1:0] wp_r, wp_nxt;
  logic [1:0] rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 3'(DEPTH));
  assign empty    = (cnt_r == 3'd0);
  assign pop_word = buf_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = wp_r + 2'd1;
    end
    if (pop) begin
      rp_nxt = rp_r + 2'd1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 3'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= push_word;
    end
  end

endmodule

// File: rtl/esp_engine.sv
module esp_engine #(
  parameter int unsigned POOL_DEPTH      = esp_pkg::POOL_DEPTH_DEF,
  parameter int unsigned SOLUTION_LENGTH = esp_pkg::SOLUTION_LENGTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  esp_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  esp_pkg::in_word_t  q_word,
  output logic               q_pop,
  output logic               res_strobe,
  output esp_pkg::out_word_t res_word
);

  localparam int unsigned SW = $clog2(POOL_DEPTH > 1 ? POOL_DEPTH : 2);
  localparam int unsigned CW = $clog2(POOL_DEPTH + 1);
  localparam int unsigned IW = $clog2(SOLUTION_LENGTH > 1 ? SOLUTION_LENGTH : 2);
  localparam int unsigned XW = $clog2(SOLUTION_LENGTH + 1);
  localparam int unsigned MEM_DEPTH = POOL_DEPTH * (2 ** IW);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_CMP    = 11'b00000000010,
    S_FIN    = 11'b00000000100,
    S_WORST  = 11'b00000001000,
    S_RANK   = 11'b00000010000,
    S_DECIDE = 11'b00000100000,
    S_SHL    = 11'b00001000000,
    S_COPY   = 11'b00010000000,
    S_INS    = 11'b00100000000,
    S_SHR    = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [31:0] entry_mem [MEM_DEPTH];
  logic signed [31:0] stage_mem [2 ** IW];
  logic signed [31:0] ent_q_r;
  logic signed [31:0] stg_q_r;

  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [XW-1:0]       idx_r, idx_nxt;
  logic [POOL_DEPTH-1:0] sim_r, sim_nxt;
  logic [SW-1:0]       om_r [POOL_DEPTH];
  logic [SW-1:0]       om_nxt [POOL_DEPTH];
  logic signed [31:0]  obj_r [POOL_DEPTH];
  logic                obj_we;

  logic signed [31:0]  e_r, e_nxt, v_r, v_nxt, wv_r, wv_nxt;
  logic                last_r, last_nxt, hw_r, hw_nxt, pend_r, pend_nxt;
  logic [CW-1:0]       r_r, r_nxt, ps_r, ps_nxt, n_r, n_nxt, k_r, k_nxt;
  logic [XW-1:0]       c_r, c_nxt;
  logic [IW-1:0]       pc_r, pc_nxt;
  logic [SW-1:0]       ws_r, ws_nxt, wr_r, wr_nxt, slot_r, slot_nxt;
  logic [1:0]          oc_r, oc_nxt;
  logic [SW-1:0]       pos_r, pos_nxt;

  logic                ent_re, ent_we, stg_we, stg_re;
  logic [SW+IW-1:0]    ent_raddr, ent_waddr;
  logic [IW-1:0]       stg_raddr;

  logic signed [32:0]  diff;
  logic [32:0]         mag;
  logic signed [32:0]  vdiff;
  logic [32:0]         vmag;
  logic [SW-1:0]       sl;
  logic signed [31:0]  ev;
  logic [8:0]          lim;
  logic [POOL_DEPTH-1:0] live;

  function automatic logic better(input logic maxm, input logic signed [31:0] a,
                                  input logic signed [31:0] b);
    better = maxm ? (a > b) : (a < b);
  endfunction

  assign diff = {e_r[31], e_r} - {ent_q_r[31], ent_q_r};
  assign mag  = diff[32] ? 33'(-diff) : 33'(diff);

  always_comb begin
    for (int s = 0; s < POOL_DEPTH; s++) begin
      live[s] = (CW'(s) < cnt_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    sim_nxt = sim_r;
    om_nxt  = om_r;
    e_nxt = e_r; v_nxt = v_r; wv_nxt = wv_r;
    last_nxt = last_r; hw_nxt = hw_r; pend_nxt = 1'b0;
    r_nxt = r_r; ps_nxt = ps_r; n_nxt = n_r; k_nxt = k_r;
    c_nxt = c_r; pc_nxt = pc_r;
    ws_nxt = ws_r; wr_nxt = wr_r; slot_nxt = slot_r;
    oc_nxt = oc_r; pos_nxt = pos_r;
    q_pop = 1'b0;
    ent_re = 1'b0; ent_we = 1'b0; stg_we = 1'b0; stg_re = 1'b0;
    ent_raddr = '0; ent_waddr = '0; stg_raddr = '0;
    obj_we = 1'b0;
    sl = '0; ev = '0; vdiff = '0; vmag = '0; lim = '0;

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          e_nxt    = q_word.element_value;
          v_nxt    = q_word.objective_value;
          last_nxt = q_word.last_element;
          if (idx_r < XW'(SOLUTION_LENGTH)) begin
            stg_we    = 1'b1;
            r_nxt     = '0;
            state_nxt = S_CMP;
          end else if (q_word.last_element) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_CMP: begin
        if (r_r < cnt_r) begin
          ent_re    = 1'b1;
          ent_raddr = {r_r[SW-1:0], idx_r[IW-1:0]};
          pend_nxt  = 1'b1;
          ps_nxt    = r_r;
          r_nxt     = r_r + CW'(1);
        end
        if (pend_r && (mag > {2'b00, cfg.match_tol})) begin
          sim_nxt[ps_r[SW-1:0]] = 1'b0;
        end
        if (r_r == cnt_r && !pend_r) begin
          idx_nxt   = idx_r + XW'(1);
          state_nxt = last_r ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        if (|(sim_r & live)) begin
          oc_nxt    = esp_pkg::OC_DUPLICATE;
          pos_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          r_nxt     = '0;
          hw_nxt    = 1'b0;
          state_nxt = S_WORST;
        end
      end
      S_WORST: begin
        if (r_r < cnt_r) begin
          sl = cfg.keep_sorted ? om_r[r_r[SW-1:0]] : r_r[SW-1:0];
          if (!hw_r || better(cfg.maximize_mode, wv_r, obj_r[sl])) begin
            hw_nxt = 1'b1;
            wv_nxt = obj_r[sl];
            ws_nxt = sl;
          end
          r_nxt = r_r + CW'(1);
        end else begin
          r_nxt     = '0;
          wr_nxt    = '0;
          state_nxt = S_RANK;
        end
      end
      S_RANK: begin
        if (r_r < cnt_r) begin
          if (om_r[r_r[SW-1:0]] == ws_r) begin
            wr_nxt = r_r[SW-1:0];
          end
          r_nxt = r_r + CW'(1);
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        lim = ({4'b0000, cfg.pool_limit} > 9'(POOL_DEPTH)) ? 9'(POOL_DEPTH)
                                                           : {4'b0000, cfg.pool_limit};
        c_nxt = '0;
        if (9'(cnt_r) < lim) begin
          oc_nxt    = esp_pkg::OC_APPENDED;
          slot_nxt  = cnt_r[SW-1:0];
          n_nxt     = cnt_r;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_COPY;
        end else if (hw_r && better(cfg.maximize_mode, v_r, wv_r)) begin
          oc_nxt    = esp_pkg::OC_REPLACED;
          slot_nxt  = ws_r;
          n_nxt     = cnt_r - CW'(1);
          r_nxt     = CW'(wr_r);
          state_nxt = S_SHL;
        end else begin
          oc_nxt    = esp_pkg::OC_NOT_BETTER;
          pos_nxt   = '0;
          state_nxt = S_OUT;
        end
      end
      S_SHL: begin
        if (r_r < n_r) begin
          om_nxt[r_r[SW-1:0]] = om_r[SW'(r_r + CW'(1))];
          r_nxt = r_r + CW'(1);
        end else begin
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        if (c_r < idx_r) begin
          stg_re    = 1'b1;
          stg_raddr = c_r[IW-1:0];
          pend_nxt  = 1'b1;
          pc_nxt    = c_r[IW-1:0];
          c_nxt     = c_r + XW'(1);
        end
        if (pend_r) begin
          ent_we    = 1'b1;
          ent_waddr = {slot_r, pc_r};
        end
        if (c_r == idx_r && !pend_r) begin
          obj_we    = 1'b1;
          r_nxt     = '0;
          k_nxt     = n_r;
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        if (r_r < n_r) begin
          ev    = obj_r[om_r[r_r[SW-1:0]]];
          vdiff = {v_r[31], v_r} - {ev[31], ev};
          vmag  = vdiff[32] ? 33'(-vdiff) : 33'(vdiff);
          if ((vmag < {2'b00, cfg.match_tol}) ||
              better(cfg.maximize_mode, v_r, ev)) begin
            k_nxt     = r_r;
            r_nxt     = n_r;
            state_nxt = S_SHR;
          end else begin
            r_nxt = r_r + CW'(1);
          end
        end else begin
          k_nxt     = n_r;
          r_nxt     = n_r;
          state_nxt = S_SHR;
        end
      end
      S_SHR: begin
        if (r_r > k_r) begin
          om_nxt[r_r[SW-1:0]] = om_r[SW'(r_r - CW'(1))];
          r_nxt = r_r - CW'(1);
        end else begin
          om_nxt[k_r[SW-1:0]] = slot_r;
          pos_nxt   = cfg.keep_sorted ? k_r[SW-1:0] : slot_r;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        idx_nxt   = '0;
        sim_nxt   = '1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_strobe          = (state_r == S_OUT);
  assign res_word.accepted   = oc_r[1];
  assign res_word.outcome    = oc_r;
  assign res_word.position   = 4'(pos_r);
  assign res_word.pool_count = 5'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      sim_r   <= '1;
      pend_r  <= 1'b0;
      for (int s = 0; s < POOL_DEPTH; s++) begin
        om_r[s] <= SW'(s);
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      sim_r   <= sim_nxt;
      pend_r  <= pend_nxt;
      om_r    <= om_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r <= e_nxt; v_r <= v_nxt; wv_r <= wv_nxt;
    last_r <= last_nxt; hw_r <= hw_nxt;
    r_r <= r_nxt; ps_r <= ps_nxt; n_r <= n_nxt; k_r <= k_nxt;
    c_r <= c_nxt; pc_r <= pc_nxt;
    ws_r <= ws_nxt; wr_r <= wr_nxt; slot_r <= slot_nxt;
    oc_r <= oc_nxt; pos_r <= pos_nxt;
    if (obj_we) begin
      obj_r[slot_r] <= v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      entry_mem[ent_waddr] <= stg_q_r;
    end
    if (ent_re) begin
      ent_q_r <= entry_mem[ent_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_we) begin
      stage_mem[idx_r[IW-1:0]] <= q_word.element_value;
    end
    if (stg_re) begin
      stg_q_r <= stage_mem[stg_raddr];
    end
  end

endmodule

// File: rtl/elite_solution_pool.sv
// Elite solution pool.
// A candidate solution arrives one word per element on in_word: assert start
// with a word while busy is low and the word is taken at that clock edge.
// The word with last_element set also carries the objective value.
// A short word queue sits in front of the engine, so busy only rises when
// that queue is full; the engine then works through the queued words.
// For each element every held entry is read once from the element memory,
// one per cycle, and compared with the element.
// After the last element the engine, unless it found a duplicate, searches
// the worst entry; if the candidate is kept it moves the rank list and
// copies the staged vector into the element memory.
// Exactly one result word appears on out_word for one cycle, flagged by
// out_strobe, for each candidate; the receiver cannot stall it.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while the block is idle; the block does not enforce it.
// Synchronous reset empties the pool, resets rank order and register values.
module elite_solution_pool #(
  parameter int unsigned POOL_DEPTH      = esp_pkg::POOL_DEPTH_DEF,
  parameter int unsigned SOLUTION_LENGTH = esp_pkg::SOLUTION_LENGTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  esp_pkg::in_word_t                in_word,
  output logic                             out_strobe,
  output esp_pkg::out_word_t               out_word,
  input  logic                             cfg_we,
  input  logic [esp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [esp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  esp_pkg::cfg_t     cfg_r, cfg_nxt;
  esp_pkg::in_word_t q_word;
  logic              q_full, q_empty, q_pop;

  // Register writes; an index past the register list is ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        esp_pkg::REG_MAXIMIZE:  cfg_nxt.maximize_mode = cfg_data[0];
        esp_pkg::REG_LIMIT:     cfg_nxt.pool_limit    = cfg_data[4:0];
        esp_pkg::REG_SORTED:    cfg_nxt.keep_sorted   = cfg_data[0];
        esp_pkg::REG_THRESHOLD: cfg_nxt.match_tol     = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.maximize_mode <= 1'b0;
      cfg_r.pool_limit    <= 5'd16;
      cfg_r.keep_sorted   <= 1'b1;
      cfg_r.match_tol     <= 31'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign busy = q_full;

  // Front end: buffers incoming words so the host is rarely held off.
  esp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (start && !q_full),
    .push_word (in_word),
    .full      (q_full),
    .pop       (q_pop),
    .pop_word  (q_word),
    .empty     (q_empty)
  );

  // Back end: compares, ranks and stores candidates.
  esp_engine #(
    .POOL_DEPTH      (POOL_DEPTH),
    .SOLUTION_LENGTH (SOLUTION_LENGTH)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_word     (q_word),
    .q_pop      (q_pop),
    .res_strobe (out_strobe),
    .res_word   (out_word)
  );

endmodule
